// ===== hdl/sorq_pkg.sv =====
// sorq_pkg: shared types and codes for the stack of ring queues
// no dependencies; used by the interfaces, the top level and the checker
package sorq_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

endpackage

// ===== hdl/sorq_req_if.sv =====
// sorq_req_if: request channel (valid/ready, action and value)
// depends on sorq_pkg
interface sorq_req_if import sorq_pkg::*;;
    logic  valid;
    logic  ready;
    logic  action;
    data_t data_in;

    modport source (output valid, output action, output data_in, input ready);
    modport sink (input valid, input action, input data_in, output ready);
endinterface

// ===== hdl/sorq_rsp_if.sv =====
// sorq_rsp_if: response channel (valid/ready, removed value and status)
// depends on sorq_pkg
interface sorq_rsp_if import sorq_pkg::*;;
    logic    valid;
    logic    ready;
    data_t   data_out;
    status_t status;

    modport source (output valid, output data_out, output status, input ready);
    modport sink (input valid, input data_out, input status, output ready);
endinterface

// ===== hdl/sorq_ram.sv =====
// sorq_ram: generic single write port, single read port ram with registered read
// no dependencies
module sorq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/stack_of_ring_queues.sv =====
// stack_of_ring_queues: stack of fixed-size circular queues, one request per transaction
// depends on sorq_pkg, sorq_req_if, sorq_rsp_if and sorq_ram
// the result of a request is registered and valid in the cycle after it is accepted
// throughput: one request per cycle; the output register stalls input only when held
// the top queue's head and count and the head of the queue below sit in registers,
// deeper heads in a small ram read one level ahead
// reset clears the stack level, the top and below head and count registers and the output valid; storage is not cleared
module stack_of_ring_queues import sorq_pkg::*; #(
    parameter int QUEUE_DEPTH = 4,
    parameter int NUM_QUEUES  = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    sorq_req_if.sink     req,
    sorq_rsp_if.source   rsp
);

    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = $clog2(NUM_QUEUES + 1);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int EN = NUM_QUEUES * QUEUE_DEPTH;
    localparam int EW = (EN > 1) ? $clog2(EN) : 1;

    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
    localparam logic [LW-1:0] LVL_MAX  = LW'(NUM_QUEUES);
    localparam logic [HW-1:0] HEAD_LAST = HW'(QUEUE_DEPTH - 1);

    logic [LW-1:0] level_reg, level_next;
    logic [HW-1:0] top_head_reg, top_head_next;
    logic [CW-1:0] top_count_reg, top_count_next;
    logic [HW-1:0] below_head_reg, below_head_next;
    logic          out_valid_reg;
    status_t       status_reg, status_next;
    logic          from_ram_reg, from_ram_next;

    logic          accept;
    logic          need_new;
    logic [QW-1:0] top_q;
    logic [EW-1:0] top_base;
    logic [EW-1:0] new_base;
    logic [HW:0]   tail_sum;
    logic [HW-1:0] tail;
    logic [HW-1:0] head_inc;

    logic          ent_we;
    logic [EW-1:0] ent_waddr;
    logic [DATA_W-1:0] ent_rdata;
    logic          hs_we;
    logic [QW-1:0] hs_raddr;
    logic [HW-1:0] hs_rdata;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign need_new = (level_reg == '0) || (top_count_reg == CNT_FULL);
    assign top_q    = QW'(level_reg - LW'(1));
    assign top_base = EW'(top_q) * EW'(QUEUE_DEPTH);
    assign new_base = EW'(level_reg) * EW'(QUEUE_DEPTH);
    assign tail_sum = (HW + 1)'(top_head_reg) + (HW + 1)'(top_count_reg);
    assign tail     = (tail_sum >= (HW + 1)'(QUEUE_DEPTH)) ?
                      HW'(tail_sum - (HW + 1)'(QUEUE_DEPTH)) : HW'(tail_sum);
    assign head_inc = (top_head_reg == HEAD_LAST) ? '0 : top_head_reg + HW'(1);

    always_comb
    begin
        level_next      = level_reg;
        top_head_next   = top_head_reg;
        top_count_next  = top_count_reg;
        below_head_next = below_head_reg;
        status_next     = ST_OK;
        from_ram_next   = 1'b0;
        ent_we          = 1'b0;
        ent_waddr       = top_base + EW'(tail);
        hs_we           = 1'b0;
        if (accept)
        begin
            if (req.action == ACT_ADD)
            begin
                if (need_new && (level_reg == LVL_MAX))
                begin
                    status_next = ST_FULL;
                end
                else if (need_new)
                begin
                    // open a new queue; the old top goes below it
                    ent_we          = 1'b1;
                    ent_waddr       = new_base;
                    hs_we           = (level_reg != '0);
                    below_head_next = top_head_reg;
                    top_head_next   = '0;
                    top_count_next  = CW'(1);
                    level_next      = level_reg + LW'(1);
                end
                else
                begin
                    ent_we         = 1'b1;
                    top_count_next = top_count_reg + CW'(1);
                end
            end
            else
            begin
                if (level_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    from_ram_next = 1'b1;
                    if (top_count_reg == CW'(1))
                    begin
                        // queue emptied: drop it, the one below is full
                        level_next = level_reg - LW'(1);
                        if (level_reg != LW'(1))
                        begin
                            top_head_next   = below_head_reg;
                            top_count_next  = CNT_FULL;
                            below_head_next = hs_rdata;
                        end
                        else
                        begin
                            top_head_next  = '0;
                            top_count_next = '0;
                        end
                    end
                    else
                    begin
                        top_head_next  = head_inc;
                        top_count_next = top_count_reg - CW'(1);
                    end
                end
            end
        end
    end

    // prefetch the head two levels below the new top
    assign hs_raddr = QW'(level_next - LW'(3));

    sorq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (EN)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ent_we),
        .wr_addr (ent_waddr),
        .wr_data (req.data_in),
        .rd_en   (accept),
        .rd_addr (top_base + EW'(top_head_reg)),
        .rd_data (ent_rdata)
    );

    sorq_ram #(
        .WIDTH (HW),
        .DEPTH (NUM_QUEUES)
    ) u_head_stack (
        .clk     (clk),
        .wr_en   (hs_we),
        .wr_addr (top_q),
        .wr_data (top_head_reg),
        .rd_en   (accept),
        .rd_addr (hs_raddr),
        .rd_data (hs_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            top_head_reg   <= '0;
            top_count_reg  <= '0;
            below_head_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            level_reg      <= level_next;
            top_head_reg   <= top_head_next;
            top_count_reg  <= top_count_next;
            below_head_reg <= below_head_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            from_ram_reg <= from_ram_next;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = status_reg;
    assign rsp.data_out = from_ram_reg ? data_t'(ent_rdata) : '0;

endmodule

// ===== hdl/sorq_checker.sv =====
// sorq_checker: port-level assertions for stack_of_ring_queues, with its bind
// depends on sorq_pkg and stack_of_ring_queues
module sorq_checker import sorq_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    req_valid,
    input logic    req_ready,
    input logic    req_action,
    input logic    rsp_valid,
    input logic    rsp_ready,
    input data_t   rsp_data_out,
    input status_t rsp_status
);

    // stalled response holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out) && $stable(rsp_status))
    else $error("response changed while stalled");

    // every accepted transaction yields a response next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
    else $error("no response after accepted request");

    // refused requests carry zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> rsp_data_out == '0)
    else $error("nonzero data on refused request");

    // add is never refused as empty
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == ACT_ADD) |=> rsp_status != ST_EMPTY)
    else $error("add answered with empty");

    // remove is never refused as full
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_action == ACT_REMOVE) |=> rsp_status != ST_FULL)
    else $error("remove answered with full");

endmodule

bind stack_of_ring_queues sorq_checker u_sorq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_action   (req.action),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_data_out (rsp.data_out),
    .rsp_status   (rsp.status)
);

// ===== tb/sv/stack_of_ring_queues_tb.sv =====
// stack_of_ring_queues_tb: self-checking testbench for the stack of ring queues
// drives requests with random gaps and output stalls, predicts each status and value
// depends on sorq_pkg, sorq_req_if, sorq_rsp_if and stack_of_ring_queues
`timescale 1ns / 1ps

module stack_of_ring_queues_tb;
    import sorq_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int NUM_QUEUES  = 4;
    localparam int SLOTS       = QUEUE_DEPTH * NUM_QUEUES;
    localparam int HOLD_CYCLES = 40;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 600;

    typedef struct {
        data_t   value;
        status_t status;
    } queue_result_t;

    logic clk;
    logic rst_n;

    sorq_req_if req_ch ();
    sorq_rsp_if rsp_ch ();

    stack_of_ring_queues #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .NUM_QUEUES (NUM_QUEUES)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // predicted state of the block
    data_t slot_mem [SLOTS];
    int    q_head   [NUM_QUEUES];
    int    q_count  [NUM_QUEUES];
    int    open_queues;

    queue_result_t pending_results[$];
    int  error_count;
    int  stalled_cycles;
    bit  idle_en;
    bit  hold_output;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic queue_result_t predict_request(logic act, data_t value);
        queue_result_t r;
        int top;
        bit open_new;
        r.value  = '0;
        r.status = ST_OK;
        if (act == ACT_ADD)
        begin
            open_new = (open_queues == 0) || (q_count[open_queues-1] >= QUEUE_DEPTH);
            if (open_new && open_queues >= NUM_QUEUES)
                r.status = ST_FULL;
            else
            begin
                if (open_new)
                begin
                    top = open_queues;
                    q_head[top]  = 0;
                    q_count[top] = 0;
                    open_queues++;
                end
                else
                    top = open_queues - 1;
                slot_mem[top*QUEUE_DEPTH + (q_head[top] + q_count[top]) % QUEUE_DEPTH] = value;
                q_count[top]++;
            end
        end
        else if (open_queues == 0)
            r.status = ST_EMPTY;
        else
        begin
            top = open_queues - 1;
            r.value = slot_mem[top*QUEUE_DEPTH + q_head[top]];
            q_head[top] = (q_head[top] + 1) % QUEUE_DEPTH;
            q_count[top]--;
            if (q_count[top] == 0)
            begin
                q_head[top] = 0;
                open_queues--;
            end
        end
        return r;
    endfunction

    task automatic send_request(logic act, data_t value);
        int gap;
        gap = idle_en ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid   = 1'b1;
        req_ch.action  = act;
        req_ch.data_in = value;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_results.push_back(predict_request(act, value));
    endtask

    task automatic wait_all_results();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(int n, int add_pct);
        logic act;
        for (int i = 0; i < n; i++)
        begin
            act = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_REMOVE;
            send_request(act, data_t'($urandom));
        end
    endtask

    // receiver: random stalls, long hold-off on request
    initial
    begin
        int w;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                hold_output = 1'b0;
                @(negedge clk);
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            w = idle_en ? $urandom_range(0, 5) : 0;
            if (w > 0)
            begin
                @(negedge clk);
                rsp_ch.ready = 1'b0;
                repeat (w - 1) @(negedge clk);
            end
            @(negedge clk);
            rsp_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        queue_result_t exp_r;
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected transaction data_out %0d status %0d",
                         $time, rsp_ch.data_out, rsp_ch.status);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (rsp_ch.data_out !== exp_r.value)
                begin
                    $display("%0t: data_out mismatch expected %0d actual %0d",
                             $time, exp_r.value, rsp_ch.data_out);
                    error_count++;
                end
                if (rsp_ch.status !== exp_r.status)
                begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, exp_r.status, rsp_ch.status);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, stalled_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic test_remove_when_empty();
        send_request(ACT_REMOVE, 32'sh1234_5678);
    endtask

    task automatic test_fill_all_queues();
        data_t corner[7];
        corner = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'shFFFF_FFFF,
                   32'sh1, 32'sh5555_5555, 32'shAAAA_AAAA};
        for (int i = 0; i < SLOTS; i++)
            send_request(ACT_ADD, (i < 7) ? corner[i] : data_t'($urandom));
        send_request(ACT_ADD, 32'sh0BAD_0BAD);
    endtask

    task automatic test_ring_wrap();
        repeat (2) send_request(ACT_REMOVE, data_t'($urandom));
        repeat (2) send_request(ACT_ADD, data_t'($urandom));
        send_request(ACT_ADD, data_t'($urandom));
        repeat (4) send_request(ACT_REMOVE, data_t'($urandom));
    endtask

    task automatic test_output_backpressure();
        wait_all_results();
        hold_output = 1'b1;
        idle_en = 1'b0;
        send_random(24, 60);
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int sent;
        int seg;
        int pct;
        int seg_idx;
        sent = 0;
        seg_idx = 0;
        while (sent < RANDOM_ITEMS)
        begin
            seg = $urandom_range(20, 50);
            case ($urandom_range(0, 4))
                0, 1: pct = 75;
                2, 3: pct = 25;
                default: pct = 50;
            endcase
            idle_en = ($urandom_range(0, 3) != 0);
            send_random(seg, pct);
            sent += seg;
            seg_idx++;
            if (seg_idx % 4 == 0)
                wait_all_results();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.action  = ACT_ADD;
        req_ch.data_in = '0;
        error_count    = 0;
        stalled_cycles = 0;
        idle_en        = 1'b1;
        hold_output    = 1'b0;
        open_queues    = 0;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            q_head[i]  = 0;
            q_count[i] = 0;
        end
        for (int i = 0; i < SLOTS; i++)
            slot_mem[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_remove_when_empty();
        test_fill_all_queues();
        test_ring_wrap();
        test_output_backpressure();
        idle_en = 1'b1;
        test_random_traffic();

        @(negedge clk);
        req_ch.valid = 1'b0;
        wait_all_results();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
